>>> src/tmhc_pkg.sv
`default_nettype none
package tmhc_pkg;

  localparam int NUMBER_W          = 44;
  localparam int OUTCOME_W         = 2;
  localparam int COUNT_W           = 12;
  localparam int LENGTH_W          = 7;
  localparam int WORD_W            = 64;
  localparam int WINDOWS           = 7;
  localparam int WIN_W             = 3;
  localparam int TAPE_CELLS_DEF    = 100;
  localparam int STATE_COUNT_DEF   = 5;

  localparam logic [OUTCOME_W-1:0] OUT_HALT      = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_LOOP      = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_OVERFLOW  = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUT_UNDECIDED = 2'd3;

  // per-cycle control broadcast to every tape cell
  typedef struct packed {
    logic clear;
    logic step;
    logic move_left;
    logic write_bit;
    logic snap_take;
    logic snap_shift;
  } cell_ctrl_t;

  // step count at which each window closes
  function automatic logic [COUNT_W-1:0] window_end(input logic [WIN_W-1:0] idx);
    logic [COUNT_W-1:0] r;
    case (idx)
      3'd0:    r = 12'd4;
      3'd1:    r = 12'd16;
      3'd2:    r = 12'd48;
      3'd3:    r = 12'd96;
      3'd4:    r = 12'd300;
      3'd5:    r = 12'd1000;
      default: r = 12'd2500;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/tmhc_if.sv
`default_nettype none
interface tmhc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tmhc_pkg::NUMBER_W-1:0] machine_number;

  modport source (output valid, machine_number, input ready);
  modport sink   (input valid, machine_number, output ready);
endinterface

interface tmhc_out_if;
  logic                           valid;
  logic                           ready;
  logic [tmhc_pkg::OUTCOME_W-1:0] outcome;
  logic [tmhc_pkg::COUNT_W-1:0]   step_count;
  logic [tmhc_pkg::LENGTH_W-1:0]  tape_length;
  logic [tmhc_pkg::WORD_W-1:0]    tape_word;
  logic                           word_index;
  logic                           last;

  modport source (output valid, outcome, step_count, tape_length, tape_word, word_index, last,
                  input ready);
  modport sink   (input valid, outcome, step_count, tape_length, tape_word, word_index, last,
                  output ready);
endinterface
`default_nettype wire

>>> src/tmhc_cell.sv
`default_nettype none
module tmhc_cell #(
  parameter bit IS_START = 1'b0
) (
  input  wire logic                 clk,
  input  wire tmhc_pkg::cell_ctrl_t ctrl,
  input  wire logic                 in_win,
  input  wire logic                 head_left,
  input  wire logic                 head_right,
  input  wire logic                 snap_left,
  output logic                      head,
  output logic                      tape,
  output logic                      snap,
  output logic                      mismatch
);

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      tape <= 1'b0;
      head <= IS_START;
    end else if (ctrl.step) begin
      if (head) begin
        tape <= ctrl.write_bit;
      end
      head <= ctrl.move_left ? head_right : head_left;
    end
  end

  // snapshot kept aligned to the right edge: shifts up as the edge grows
  always_ff @(posedge clk) begin
    if (ctrl.snap_take) begin
      snap <= tape;
    end else if (ctrl.snap_shift) begin
      snap <= snap_left;
    end
  end

  assign mismatch = in_win & (tape ^ snap);

endmodule
`default_nettype wire

>>> src/tmhc_digits.sv
`default_nettype none
module tmhc_digits #(
  parameter int STATE_COUNT = tmhc_pkg::STATE_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic [tmhc_pkg::NUMBER_W-1:0]     number,
  input  wire logic [$clog2(2*STATE_COUNT)-1:0]  rule_idx,
  output logic [$clog2(4*STATE_COUNT)-1:0]       rule,
  output logic                                   done
);

  localparam int BASE   = 4 * STATE_COUNT;
  localparam int DIGITS = 2 * STATE_COUNT;
  localparam int DW     = $clog2(BASE);
  localparam int CW     = $clog2(tmhc_pkg::NUMBER_W);

  logic [tmhc_pkg::NUMBER_W-1:0] bits;
  logic [CW-1:0]                 count;
  logic                          busy;
  logic [DW-1:0]                 digit [DIGITS];
  logic [DIGITS:0]               carry;

  // binary to base-4S, MSB first: each digit doubles and adds the carry from below
  assign carry[0] = bits[tmhc_pkg::NUMBER_W-1];

  for (genvar i = 0; i < DIGITS; i++) begin : g_dig
    logic [DW:0] dbl;
    assign carry[i+1] = (digit[i] >= DW'(BASE / 2));
    assign dbl        = {digit[i], carry[i]} - (carry[i+1] ? (DW+1)'(BASE) : '0);
    always_ff @(posedge clk) begin
      if (start) begin
        digit[i] <= '0;
      end else if (busy) begin
        digit[i] <= dbl[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      bits  <= number;
      count <= CW'(tmhc_pkg::NUMBER_W - 1);
    end else if (busy) begin
      bits  <= bits << 1;
      count <= count - 1'b1;
    end
  end

  assign rule = digit[rule_idx];

endmodule
`default_nettype wire

>>> src/turing_machine_halt_classifier.sv
`default_nettype none
// Classifies one two-symbol busy-beaver machine per transfer. The 44-bit
// machine number is unpacked into 2*STATE_COUNT rule digits (one input bit a
// cycle), then the machine runs on a row of TAPE_CELLS+1 cells, one machine
// step per cycle between window boundaries, with the head as a marker that
// walks the row and a right-edge-aligned snapshot held in each cell so the
// loop test is a parallel compare. Each of the seven windows opens with a
// snapshot state and closes without a step; an item runs at most 2499
// machine steps. A new item is taken only once the last result of the
// previous one has gone. A halt gives two results (tape cells 1..64, then
// 65..128 with last set); every other outcome gives one, with tape_length
// and tape_word zero.
module turing_machine_halt_classifier #(
  parameter int TAPE_CELLS  = tmhc_pkg::TAPE_CELLS_DEF,
  parameter int STATE_COUNT = tmhc_pkg::STATE_COUNT_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  tmhc_in_if.sink     item,
  tmhc_out_if.source  result
);

  localparam int HW = $clog2(TAPE_CELLS + 2);
  localparam int SW = $clog2(STATE_COUNT);
  localparam int DW = $clog2(4 * STATE_COUNT);
  localparam int IW = $clog2(2 * STATE_COUNT);
  localparam int CW = tmhc_pkg::COUNT_W;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_SNAP = 5'b00100,
    S_RUN  = 5'b01000,
    S_OUT  = 5'b10000
  } fsm_t;

  fsm_t fsm, fsm_next;

  // machine registers
  logic [SW-1:0]                  mstate, snap_state;
  logic [HW-1:0]                  head, rightmost, leftmost, shift, offset0;
  logic [CW-1:0]                  counter;
  logic [tmhc_pkg::WIN_W-1:0]     win;
  logic                           pending;
  logic [tmhc_pkg::OUTCOME_W-1:0] outcome;
  logic [CW-1:0]                  count_out;
  logic                           word;

  tmhc_pkg::cell_ctrl_t ctrl;
  logic                 load_done;
  logic [DW-1:0]        rule;
  logic [TAPE_CELLS:0]  head_bits, tape_bits, snap_bits, mism_bits;
  logic [HW-1:0]        lo;
  logic                 sym, match;
  logic [CW-1:0]        cnt_eff;
  logic [HW-1:0]        head_new;
  logic                 is_halt;

  assign item.ready = (fsm == S_IDLE);

  tmhc_digits #(.STATE_COUNT(STATE_COUNT)) u_digits (
    .clk      (clk),
    .rst      (rst),
    .start    (item.valid && item.ready),
    .number   (item.machine_number),
    .rule_idx (IW'({mstate, sym})),
    .rule     (rule),
    .done     (load_done)
  );

  // loop window on the current tape: from the translated left edge up to the right edge
  assign lo = leftmost + shift;

  for (genvar i = 0; i <= TAPE_CELLS; i++) begin : g_cell
    logic h_left, h_right, s_left;
    if (i == 0) begin : g_lo
      assign h_left = 1'b0;
      assign s_left = 1'b0;
    end else begin : g_mid
      assign h_left = head_bits[i-1];
      assign s_left = snap_bits[i-1];
    end
    if (i == TAPE_CELLS) begin : g_hi
      assign h_right = 1'b0;
    end else begin : g_nhi
      assign h_right = head_bits[i+1];
    end
    tmhc_cell #(.IS_START(i == 1)) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .in_win     ((HW'(i) >= lo) && (HW'(i) <= rightmost)),
      .head_left  (h_left),
      .head_right (h_right),
      .snap_left  (s_left),
      .head       (head_bits[i]),
      .tape       (tape_bits[i]),
      .snap       (snap_bits[i]),
      .mismatch   (mism_bits[i])
    );
  end

  assign sym = |(head_bits & tape_bits);

  // test of the previous step, made on registered state before the next step
  assign match = pending && (mstate == snap_state) && ((rightmost - head) == offset0)
                 && !(|mism_bits);
  assign cnt_eff  = pending ? counter + 1'b1 : counter;
  assign head_new = rule[0] ? head - 1'b1 : head + 1'b1;
  assign is_halt  = (outcome == tmhc_pkg::OUT_HALT);

  always_comb begin
    fsm_next        = fsm;
    ctrl            = '0;
    ctrl.move_left  = rule[0];
    ctrl.write_bit  = rule[1];
    case (fsm)
      S_IDLE: begin
        if (item.valid) begin
          ctrl.clear = 1'b1;
          fsm_next   = S_LOAD;
        end
      end
      S_LOAD: begin
        if (load_done) begin
          fsm_next = S_SNAP;
        end
      end
      S_SNAP: begin
        ctrl.snap_take = 1'b1;
        fsm_next       = S_RUN;
      end
      S_RUN: begin
        if (match) begin
          fsm_next = S_OUT;
        end else if (cnt_eff >= tmhc_pkg::window_end(win)) begin
          fsm_next = (win == tmhc_pkg::WIN_W'(tmhc_pkg::WINDOWS - 1)) ? S_OUT : S_SNAP;
        end else begin
          ctrl.step = 1'b1;
          if ((rule[0] && head == HW'(1)) || (!rule[0] && head == HW'(TAPE_CELLS))) begin
            fsm_next = S_OUT;
          end else if (!rule[0] && head_new > rightmost) begin
            ctrl.snap_shift = 1'b1;
          end
        end
      end
      S_OUT: begin
        if (result.ready && (!is_halt || word)) begin
          fsm_next = S_IDLE;
        end
      end
      default: fsm_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm <= S_IDLE;
    end else begin
      fsm <= fsm_next;
    end
  end

  always_ff @(posedge clk) begin
    case (fsm)
      S_IDLE: begin
        mstate    <= '0;
        head      <= HW'(1);
        rightmost <= HW'(1);
        counter   <= CW'(1);
        win       <= '0;
        pending   <= 1'b0;
        word      <= 1'b0;
      end
      S_SNAP: begin
        snap_state <= mstate;
        leftmost   <= head;
        shift      <= '0;
        offset0    <= rightmost - head;
        pending    <= 1'b0;
      end
      S_RUN: begin
        if (match) begin
          outcome   <= tmhc_pkg::OUT_LOOP;
          count_out <= counter;
        end else if (cnt_eff >= tmhc_pkg::window_end(win)) begin
          counter   <= cnt_eff;
          win       <= win + 1'b1;
          outcome   <= tmhc_pkg::OUT_UNDECIDED;
          count_out <= cnt_eff;
        end else if (rule[0] && head == HW'(1)) begin
          // stepped onto cell 0: halt, and this step is counted
          outcome   <= tmhc_pkg::OUT_HALT;
          count_out <= cnt_eff + 1'b1;
        end else if (!rule[0] && head == HW'(TAPE_CELLS)) begin
          outcome   <= tmhc_pkg::OUT_OVERFLOW;
          count_out <= cnt_eff;
        end else begin
          counter <= cnt_eff;
          pending <= 1'b1;
          mstate  <= rule[DW-1:2];
          head    <= head_new;
          if (head_new > rightmost) begin
            rightmost <= head_new;
            shift     <= shift + 1'b1;
          end
          if (head_new < leftmost) begin
            leftmost <= head_new;
          end
        end
      end
      S_OUT: begin
        if (result.ready) begin
          word <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // tape words: cells 1..64 and 65..128, cells beyond the tape read 0
  logic [tmhc_pkg::WORD_W-1:0] word0, word1;
  for (genvar b = 0; b < tmhc_pkg::WORD_W; b++) begin : g_pack
    if (b + 1 <= TAPE_CELLS) begin : g_w0
      assign word0[b] = tape_bits[b + 1];
    end else begin : g_z0
      assign word0[b] = 1'b0;
    end
    if (b + 1 + tmhc_pkg::WORD_W <= TAPE_CELLS) begin : g_w1
      assign word1[b] = tape_bits[b + 1 + tmhc_pkg::WORD_W];
    end else begin : g_z1
      assign word1[b] = 1'b0;
    end
  end

  assign result.valid       = (fsm == S_OUT);
  assign result.outcome     = outcome;
  assign result.step_count  = count_out;
  assign result.tape_length = is_halt ? tmhc_pkg::LENGTH_W'(rightmost) : '0;
  assign result.tape_word   = is_halt ? (word ? word1 : word0) : '0;
  assign result.word_index  = word;
  assign result.last        = !is_halt || word;

endmodule
`default_nettype wire

>>> tb/testbench.sv
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TAPE      = tmhc_pkg::TAPE_CELLS_DEF;
  localparam int STATES    = tmhc_pkg::STATE_COUNT_DEF;
  localparam int RADIX     = 4 * STATES;
  localparam int DIGITS    = 2 * STATES;
  localparam int NUMBER_W  = tmhc_pkg::NUMBER_W;
  localparam int OUTCOME_W = tmhc_pkg::OUTCOME_W;
  localparam int COUNT_W   = tmhc_pkg::COUNT_W;
  localparam int LENGTH_W  = tmhc_pkg::LENGTH_W;
  localparam int WORD_W    = tmhc_pkg::WORD_W;

  localparam logic [OUTCOME_W-1:0] OUT_HALT      = tmhc_pkg::OUT_HALT;
  localparam logic [OUTCOME_W-1:0] OUT_LOOP      = tmhc_pkg::OUT_LOOP;
  localparam logic [OUTCOME_W-1:0] OUT_OVERFLOW  = tmhc_pkg::OUT_OVERFLOW;
  localparam logic [OUTCOME_W-1:0] OUT_UNDECIDED = tmhc_pkg::OUT_UNDECIDED;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [COUNT_W-1:0]   step_count;
    logic [LENGTH_W-1:0]  tape_length;
    logic [WORD_W-1:0]    tape_word;
    logic                 word_index;
    logic                 last;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  tmhc_in_if  item ();
  tmhc_out_if result ();

  turing_machine_halt_classifier DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item.sink),
    .result (result.source)
  );

  logic [NUMBER_W-1:0] machines_pending[$];
  verdict_t            verdicts_due[$];
  int  error_count = 0;
  bit  quiet_phase = 1'b0;   // no idling on either side
  bit  hold_off    = 1'b0;   // receiver refuses for a long stretch
  int  hold_cycles = 0;
  bit  hold_done   = 1'b0;
  bit  stim_loaded = 1'b0;
  bit  item_taken  = 1'b0;   // input transfer at the last rising edge

  // Append one machine number to the pending list.
  function automatic void queue_machine(input logic [NUMBER_W-1:0] number);
    machines_pending = {machines_pending, number};
  endfunction

  // Step the machine on a cleared tape and queue the verdicts it gives.
  function automatic void classify_machine(input logic [NUMBER_W-1:0] number);
    logic [4:0] rules[DIGITS];
    logic       tape[TAPE+1];
    logic       snap[TAPE+1];
    logic [NUMBER_W-1:0] m;
    int head, st, snap_st, right, left_w, edge_w, head_w, steps, outcome;
    int ends[7];
    bit done, hit;
    int a, b;
    logic [4:0] r;
    verdict_t v;
    ends = '{4, 16, 48, 96, 300, 1000, 2500};
    m = number;
    for (int d = 0; d < DIGITS; d++) begin
      rules[d] = 5'(m % RADIX);
      m = m / RADIX;
    end
    for (int c = 0; c <= TAPE; c++) tape[c] = 1'b0;
    head = 1; st = 0; steps = 1; right = 1;
    outcome = OUT_UNDECIDED;
    done = 1'b0;
    for (int w = 0; w < 7 && !done; w++) begin
      left_w = head; head_w = head; edge_w = right; snap_st = st;
      snap = tape;
      while (steps < ends[w] && !done) begin
        r = rules[2 * st + tape[head]];
        st = r >> 2;
        tape[head] = r[1];
        head = r[0] ? head - 1 : head + 1;
        if (head <= 0) begin
          // halt wins over the loop test on the same step
          head = 0; steps++; outcome = OUT_HALT; done = 1'b1;
        end else if (head > TAPE) begin
          outcome = OUT_OVERFLOW; done = 1'b1;
        end else begin
          if (head > right) right = head;
          if (head < left_w) left_w = head;
          hit = (st == snap_st) && (edge_w - head_w == right - head);
          for (int k = 0; hit && k <= edge_w - left_w; k++) begin
            a = right - k; b = edge_w - k;
            if (a < 0 || a > TAPE || b < 0 || b > TAPE || tape[a] != snap[b]) hit = 1'b0;
          end
          if (hit) begin
            outcome = OUT_LOOP; done = 1'b1;
          end else steps++;
        end
      end
    end
    if (outcome == OUT_HALT) begin
      for (int w = 0; w < 2; w++) begin
        v = '0;
        v.outcome = OUT_HALT;
        v.step_count = COUNT_W'(steps);
        v.tape_length = LENGTH_W'(right);
        for (int bb = 0; bb < 64; bb++)
          if (64 * w + 1 + bb <= TAPE) v.tape_word[bb] = tape[64 * w + 1 + bb];
        v.word_index = w[0];
        v.last = (w == 1);
        verdicts_due = {verdicts_due, v};
      end
    end else begin
      v = '0;
      v.outcome = outcome[OUTCOME_W-1:0];
      v.step_count = COUNT_W'(steps);
      v.last = 1'b1;
      verdicts_due = {verdicts_due, v};
    end
  endfunction

  // Machine number from explicit rule digits (state, symbol order).
  function automatic logic [NUMBER_W-1:0] pack_rules(input int dg[DIGITS]);
    logic [NUMBER_W-1:0] n = '0;
    for (int d = DIGITS - 1; d >= 0; d--) n = n * RADIX + NUMBER_W'(dg[d]);
    return n;
  endfunction

  function automatic logic [NUMBER_W-1:0] random_machine();
    int dg[DIGITS];
    for (int d = 0; d < DIGITS; d++) dg[d] = $urandom_range(RADIX - 1);
    return pack_rules(dg);
  endfunction

  // Driver: offers the next pending machine, idling now and then.
  always @(negedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else if (item.valid && !item_taken) begin
      // offer held until it is taken
    end else if (machines_pending.size() > 0 &&
                 (quiet_phase || $urandom_range(99) >= 9)) begin
      item.valid          <= 1'b1;
      item.machine_number <= machines_pending.pop_front();
    end else begin
      item.valid <= 1'b0;
    end
  end

  // Receiver ready, with a long hold-off counted here.
  always @(negedge clk) begin
    if (hold_off && !hold_done) begin
      result.ready <= 1'b0;
      hold_cycles  <= hold_cycles + 1;
      if (hold_cycles >= 6000) hold_done <= 1'b1;
    end else begin
      result.ready <= rst ? 1'b0 : (quiet_phase || $urandom_range(99) >= 9);
    end
  end

  // Monitor: predicts on each accepted transfer, checks each result transfer.
  always @(posedge clk) begin
    verdict_t want;
    item_taken = !rst && item.valid && item.ready;
    if (item_taken) classify_machine(item.machine_number);
    if (!rst && result.valid && result.ready) begin
      if (verdicts_due.size() == 0) begin
        $error("result transfer with nothing expected");
        error_count++;
      end else begin
        want = verdicts_due.pop_front();
        if (result.outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, result.outcome);
          error_count++;
        end
        if (result.step_count !== want.step_count) begin
          $error("step_count: expected %0d, got %0d", want.step_count, result.step_count);
          error_count++;
        end
        if (result.tape_length !== want.tape_length) begin
          $error("tape_length: expected %0d, got %0d", want.tape_length, result.tape_length);
          error_count++;
        end
        if (result.tape_word !== want.tape_word) begin
          $error("tape_word: expected %h, got %h", want.tape_word, result.tape_word);
          error_count++;
        end
        if (result.word_index !== want.word_index) begin
          $error("word_index: expected %0d, got %0d", want.word_index, result.word_index);
          error_count++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, result.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    item.valid = 1'b0;
    item.machine_number = '0;
    result.ready = 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    int dg[DIGITS];
    int wait_cycles;
    repeat (3) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // Directed: extremes of the number, halting, looping, overflowing machines.
    queue_machine('0);                                  // walks right over blanks: loop
    queue_machine(NUMBER_W'(64'd10239999999999));
    queue_machine({NUMBER_W{1'b1}});                    // digits above range ignored
    queue_machine(NUMBER_W'(1));                        // state 0 blank moves left: halt
    queue_machine(NUMBER_W'(3));                        // writes 1, halts
    dg = '{4, 4, 8, 8, 12, 12, 16, 16, 3, 3};           // marches right, never halts
    queue_machine(pack_rules(dg));
    dg = '{5, 1, 0, 0, 0, 0, 0, 0, 0, 0};               // moves left off the start cell: halt
    queue_machine(pack_rules(dg));
    dg = '{6, 1, 2, 2, 0, 0, 0, 0, 0, 0};               // writes ones rightwards
    queue_machine(pack_rules(dg));
    dg = '{2, 0, 0, 0, 0, 0, 0, 0, 0, 0};               // writes ones rightwards
    queue_machine(pack_rules(dg));
    dg = '{6, 13, 9, 5, 2, 17, 3, 19, 18, 1};           // busy-beaver style table
    queue_machine(pack_rules(dg));
    dg = '{7, 4, 11, 8, 15, 12, 19, 16, 2, 1};          // writes 1 and moves left off the start cell: halt
    queue_machine(pack_rules(dg));
    dg = '{6, 5, 6, 0, 0, 0, 0, 0, 0, 0};               // writes ones rightwards in state 1
    queue_machine(pack_rules(dg));
    for (int i = 0; i < 8; i++) queue_machine(NUMBER_W'({$urandom, $urandom}));

    // Pause the sender until every expected result is back.
    wait (machines_pending.size() == 0 && !item.valid);
    wait (verdicts_due.size() == 0);
    repeat (3000) @(posedge clk);

    // Random tables, with a no-idle stretch in the middle and a receiver hold-off after it.
    for (int i = 0; i < 210; i++) begin
      if (i < 20) queue_machine(NUMBER_W'({$urandom, $urandom}));
      else queue_machine(random_machine());
      if (i == 60) begin
        wait (machines_pending.size() == 0);
        quiet_phase = 1'b1;
      end
      if (i == 100) begin
        wait (machines_pending.size() == 0);
        quiet_phase = 1'b0;
        hold_off = 1'b1;       // receiver stalls while the sender keeps offering
      end
    end
    wait (machines_pending.size() == 0 && !item.valid);
    wait_cycles = 0;
    while ((verdicts_due.size() > 0 || wait_cycles < 3000) && wait_cycles < 200000) begin
      @(posedge clk);
      if (verdicts_due.size() > 0) wait_cycles = 0;
      else wait_cycles++;
    end
    if (error_count == 0 && verdicts_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire
